// File: rtl/balanced_ternary_term_emitter_macros.svh
// ----------------------------------------------------------------------------
// balanced ternary term emitter assertion macros
// immediate-cycle and next-cycle implication checks on clk, gated by rst_n
// ----------------------------------------------------------------------------
`ifndef BALANCED_TERNARY_TERM_EMITTER_MACROS_SVH
`define BALANCED_TERNARY_TERM_EMITTER_MACROS_SVH

`ifndef NO_ASSERTIONS

// consequent must hold in the same cycle as the antecedent
`define BTTE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BTTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BTTE_ASSERT_NOW(label, ante, cons, msg)
`define BTTE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// File: rtl/btte_pkg.sv
// ----------------------------------------------------------------------------
// btte_pkg
// shared types, trit codes and the power-of-three table
// ----------------------------------------------------------------------------
package btte_pkg;

    // field widths
    localparam int VALUE_W = 62;
    localparam int EXP_W   = 6;
    localparam int REM_W   = 63;

    // default and table size
    localparam int MAX_TRITS_DEFAULT = 40;
    localparam int TOP_EXP           = 39;

    // trit codes
    typedef enum logic [1:0] {
        TRIT_ZERO  = 2'd0,
        TRIT_PLUS  = 2'd1,
        TRIT_MINUS = 2'd2
    } trit_t;

    // one result item
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [EXP_W-1:0]   exponent;
        logic               minus;
        logic               last;
    } term_t;

    // result of one trit step
    typedef struct packed {
        trit_t                    trit;
        logic signed [REM_W-1:0]  rem_next;
    } step_t;

    // three to the k, k from 0 to 39
    function automatic logic [VALUE_W-1:0] pow3(input logic [EXP_W-1:0] k);
        logic [VALUE_W-1:0] p;
        case (k)
            6'd0:  p = 62'd1;
            6'd1:  p = 62'd3;
            6'd2:  p = 62'd9;
            6'd3:  p = 62'd27;
            6'd4:  p = 62'd81;
            6'd5:  p = 62'd243;
            6'd6:  p = 62'd729;
            6'd7:  p = 62'd2187;
            6'd8:  p = 62'd6561;
            6'd9:  p = 62'd19683;
            6'd10: p = 62'd59049;
            6'd11: p = 62'd177147;
            6'd12: p = 62'd531441;
            6'd13: p = 62'd1594323;
            6'd14: p = 62'd4782969;
            6'd15: p = 62'd14348907;
            6'd16: p = 62'd43046721;
            6'd17: p = 62'd129140163;
            6'd18: p = 62'd387420489;
            6'd19: p = 62'd1162261467;
            6'd20: p = 62'd3486784401;
            6'd21: p = 62'd10460353203;
            6'd22: p = 62'd31381059609;
            6'd23: p = 62'd94143178827;
            6'd24: p = 62'd282429536481;
            6'd25: p = 62'd847288609443;
            6'd26: p = 62'd2541865828329;
            6'd27: p = 62'd7625597484987;
            6'd28: p = 62'd22876792454961;
            6'd29: p = 62'd68630377364883;
            6'd30: p = 62'd205891132094649;
            6'd31: p = 62'd617673396283947;
            6'd32: p = 62'd1853020188851841;
            6'd33: p = 62'd5559060566555523;
            6'd34: p = 62'd16677181699666569;
            6'd35: p = 62'd50031545098999707;
            6'd36: p = 62'd150094635296999121;
            6'd37: p = 62'd450283905890997363;
            6'd38: p = 62'd1350851717672992089;
            6'd39: p = 62'd4052555153018976267;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

// File: rtl/balanced_ternary_term_emitter.sv
// ----------------------------------------------------------------------------
// balanced_ternary_term_emitter
// writes a positive integer as signed distinct powers of three and emits
// one item per nonzero trit, largest power first
// ----------------------------------------------------------------------------
//
//  channel   signals                                   direction
//  -------   ---------------------------------------   ---------
//  value     value_valid, value_ready, value_in         in
//  term      term_valid, term_ready, term_value,        out
//            term_exponent, is_minus, last_term
//
// one trit step a cycle through the shared compare and add/subtract unit,
// while the output register can take an item, from 3^39 down; an item runs
// 40 - e steps, e being the lowest nonzero exponent, since the run ends once
// the remainder reaches zero (a zero item runs one step).
// value_ready is high only while the sequencer is idle
// a step waits while the output register holds an item not yet taken
// asynchronous active-low reset clears the sequencer and the output valid
// ----------------------------------------------------------------------------
`include "balanced_ternary_term_emitter_macros.svh"

module balanced_ternary_term_emitter #(
    parameter int MAX_TRITS = btte_pkg::MAX_TRITS_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           value_valid,
    output logic                           value_ready,
    input  logic [btte_pkg::VALUE_W-1:0]   value_in,
    output logic                           term_valid,
    input  logic                           term_ready,
    output logic [btte_pkg::VALUE_W-1:0]   term_value,
    output logic [btte_pkg::EXP_W-1:0]     term_exponent,
    output logic                           is_minus,
    output logic                           last_term
);

    localparam logic [btte_pkg::EXP_W-1:0] WINDOW  = btte_pkg::EXP_W'(MAX_TRITS);
    localparam logic [btte_pkg::EXP_W-1:0] TOP_IDX = btte_pkg::EXP_W'(btte_pkg::TOP_EXP);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic signed [btte_pkg::REM_W-1:0]  rem_reg;
    logic signed [btte_pkg::REM_W-1:0]  rem_next;
    logic [btte_pkg::EXP_W-1:0]         idx_reg;
    logic [btte_pkg::EXP_W-1:0]         idx_next;

    btte_pkg::step_t  step;
    btte_pkg::term_t  load_term;
    logic             slot_free;
    logic             step_en;
    logic             emit;
    logic             done;
    logic             accept;

    // shared trit unit
    btte_trit_unit u_trit (
        .rem      (rem_reg),
        .exponent (idx_reg),
        .step     (step)
    );

    // step control
    assign accept  = value_valid && value_ready;
    assign step_en = (state_reg == ST_RUN) && slot_free;
    assign emit    = step_en && (step.trit != btte_pkg::TRIT_ZERO) && (idx_reg < WINDOW);
    assign done    = step_en && ((step.rem_next == '0) || (idx_reg == '0));

    // item for the output register, last once nothing remains below
    assign load_term.value    = btte_pkg::pow3(idx_reg);
    assign load_term.exponent = idx_reg;
    assign load_term.minus    = (step.trit == btte_pkg::TRIT_MINUS);
    assign load_term.last     = (step.rem_next == '0);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    rem_next   = $signed({1'b0, value_in});
                    idx_next   = TOP_IDX;
                end
            end
            ST_RUN:
            begin
                if (step_en)
                begin
                    rem_next = step.rem_next;
                    if (done)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rem_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            idx_reg   <= idx_next;
        end
    end

    assign value_ready = (state_reg == ST_IDLE);

    // output register
    btte_term_buffer u_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (emit),
        .load_term     (load_term),
        .slot_free     (slot_free),
        .term_valid    (term_valid),
        .term_ready    (term_ready),
        .term_value    (term_value),
        .term_exponent (term_exponent),
        .is_minus      (is_minus),
        .last_term     (last_term)
    );

    // checks
    `BTTE_ASSERT_NEXT(a_start, accept, (state_reg == ST_RUN) && (idx_reg == TOP_IDX), "bad start")
    `BTTE_ASSERT_NEXT(a_finish, done, value_ready, "sequencer did not return to idle")
    `BTTE_ASSERT_NOW(a_window, term_valid, term_exponent < WINDOW, "exponent out of window")
    `BTTE_ASSERT_NOW(a_power, term_valid, term_value == btte_pkg::pow3(term_exponent), "bad power")

endmodule

// File: rtl/btte_trit_unit.sv
// ----------------------------------------------------------------------------
// btte_trit_unit
// shared compare and add/subtract unit: picks the balanced trit at one
// power of three, most significant first, and updates the signed remainder
// ----------------------------------------------------------------------------
module btte_trit_unit (
    input  logic signed [btte_pkg::REM_W-1:0] rem,
    input  logic [btte_pkg::EXP_W-1:0]        exponent,
    output btte_pkg::step_t                   step
);

    logic [btte_pkg::VALUE_W-1:0]       pw;
    logic signed [btte_pkg::REM_W-1:0]  full_s;
    logic signed [btte_pkg::REM_W-1:0]  half_s;

    // power and its half, (3^k - 1) / 2 is a shift since 3^k is odd
    assign pw     = btte_pkg::pow3(exponent);
    assign full_s = $signed({1'b0, pw});
    assign half_s = $signed({2'b00, pw[btte_pkg::VALUE_W-1:1]});

    // trit is the sign of the remainder once it leaves the half band
    always_comb
    begin
        if (rem > half_s)
        begin
            step.trit     = btte_pkg::TRIT_PLUS;
            step.rem_next = rem - full_s;
        end
        else if (rem < -half_s)
        begin
            step.trit     = btte_pkg::TRIT_MINUS;
            step.rem_next = rem + full_s;
        end
        else
        begin
            step.trit     = btte_pkg::TRIT_ZERO;
            step.rem_next = rem;
        end
    end

endmodule

// File: rtl/btte_term_buffer.sv
// ----------------------------------------------------------------------------
// btte_term_buffer
// output register for result items, decouples the sequencer from the
// downstream ready
// ----------------------------------------------------------------------------
module btte_term_buffer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  btte_pkg::term_t                load_term,
    output logic                           slot_free,
    output logic                           term_valid,
    input  logic                           term_ready,
    output logic [btte_pkg::VALUE_W-1:0]   term_value,
    output logic [btte_pkg::EXP_W-1:0]     term_exponent,
    output logic                           is_minus,
    output logic                           last_term
);

    logic            valid_reg;
    logic            valid_next;
    btte_pkg::term_t term_reg;

    // slot can take a new item when empty or drained this cycle
    assign slot_free  = !valid_reg || term_ready;
    assign valid_next = load || (valid_reg && !term_ready);

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            term_reg <= load_term;
        end
    end

    // ports
    assign term_valid    = valid_reg;
    assign term_value    = term_reg.value;
    assign term_exponent = term_reg.exponent;
    assign is_minus      = term_reg.minus;
    assign last_term     = term_reg.last;

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for balanced_ternary_term_emitter
// feeds non-negative integers through the value channel and checks every emitted
// signed power-of-three term against a balanced-ternary expansion computed
// here, with random idling on both channels and one long output hold-off
// ----------------------------------------------------------------------------
module testbench;

    localparam int VW         = btte_pkg::VALUE_W;
    localparam int EW         = btte_pkg::EXP_W;
    localparam int TRIT_COUNT = btte_pkg::MAX_TRITS_DEFAULT;
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES = 100;

    // expected-term store and balanced-ternary expansion
    class term_scoreboard;
        btte_pkg::term_t pending_terms[$];
        int              errors = 0;

        // expand one value into its nonzero trits, largest power first
        function void note_value(logic [VW-1:0] v);
            logic [63:0]      rem;
            logic [63:0]      p;
            btte_pkg::trit_t  trits[TRIT_COUNT];
            logic [VW-1:0]    powers[TRIT_COUNT];
            int               lowest;
            bit               any;
            btte_pkg::term_t  t;
            rem = {2'b00, v};
            p = 64'd1;
            lowest = 0;
            any = 1'b0;
            // divide by three, rounding up on a remainder of two
            for (int i = 0; i < TRIT_COUNT; i++)
            begin
                case (rem % 3)
                    64'd0:
                    begin
                        trits[i] = btte_pkg::TRIT_ZERO;
                        rem = rem / 3;
                    end
                    64'd1:
                    begin
                        trits[i] = btte_pkg::TRIT_PLUS;
                        rem = (rem - 1) / 3;
                    end
                    default:
                    begin
                        trits[i] = btte_pkg::TRIT_MINUS;
                        rem = (rem + 1) / 3;
                    end
                endcase
                powers[i] = p[VW-1:0];
                p = p * 3;
                if (trits[i] != btte_pkg::TRIT_ZERO && !any)
                begin
                    lowest = i;
                    any = 1'b1;
                end
            end
            if (!any)
                return;
            // emit from the top power down
            for (int i = TRIT_COUNT - 1; i >= 0; i--)
            begin
                if (trits[i] != btte_pkg::TRIT_ZERO)
                begin
                    t.value    = powers[i];
                    t.exponent = EW'(i);
                    t.minus    = (trits[i] == btte_pkg::TRIT_MINUS);
                    t.last     = (i == lowest);
                    pending_terms = {pending_terms, t};
                end
            end
        endfunction

        // compare one emitted term with the oldest expected one
        function void check_term(logic [VW-1:0] value, logic [EW-1:0] exponent,
                                 logic minus, logic last);
            btte_pkg::term_t e;
            if (pending_terms.size() == 0)
            begin
                $error("unexpected term: term_value %0d term_exponent %0d",
                       value, exponent);
                errors++;
                return;
            end
            e = pending_terms.pop_front();
            if (value !== e.value)
            begin
                $error("term_value mismatch: expected %0d actual %0d", e.value, value);
                errors++;
            end
            if (exponent !== e.exponent)
            begin
                $error("term_exponent mismatch: expected %0d actual %0d",
                       e.exponent, exponent);
                errors++;
            end
            if (minus !== e.minus)
            begin
                $error("is_minus mismatch: expected %0b actual %0b", e.minus, minus);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last_term mismatch: expected %0b actual %0b", e.last, last);
                errors++;
            end
        endfunction

        function int pending_count();
            return pending_terms.size();
        endfunction
    endclass

    logic            clk;
    logic            rst_n = 1'b0;
    logic            value_valid = 1'b0;
    logic            value_ready;
    logic [VW-1:0]   value_in = '0;
    logic            term_valid;
    logic            term_ready = 1'b0;
    logic [VW-1:0]   term_value;
    logic [EW-1:0]   term_exponent;
    logic            is_minus;
    logic            last_term;

    bit              no_idle = 1'b0;
    term_scoreboard  sb = new;

    balanced_ternary_term_emitter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .value_valid   (value_valid),
        .value_ready   (value_ready),
        .value_in      (value_in),
        .term_valid    (term_valid),
        .term_ready    (term_ready),
        .term_value    (term_value),
        .term_exponent (term_exponent),
        .is_minus      (is_minus),
        .last_term     (last_term)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // overall time limit
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    // accepted items on both channels
    always @(posedge clk)
    begin
        if (rst_n && value_valid && value_ready)
            sb.note_value(value_in);
        if (rst_n && term_valid && term_ready)
            sb.check_term(term_value, term_exponent, is_minus, last_term);
    end

    function automatic logic [VW-1:0] three_pow(int k);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++)
            p = p * 3;
        return p[VW-1:0];
    endfunction

    // random value: full width, small, near a power of three, masked width, or zero
    function automatic logic [VW-1:0] random_value();
        int            sel;
        int            k;
        int            bits;
        logic [63:0]   w;
        logic [VW-1:0] p;
        sel = $urandom_range(0, 99);
        w = {$urandom(), $urandom()};
        if (sel < 40)
            return w[VW-1:0];
        if (sel < 60)
            return VW'($urandom_range(1, 1000));
        if (sel < 80)
        begin
            k = $urandom_range(0, TRIT_COUNT - 1);
            p = three_pow(k);
            if (p > 2)
                return p + VW'($urandom_range(0, 4)) - VW'(2);
            return p;
        end
        if (sel < 98)
        begin
            bits = $urandom_range(1, VW);
            return w[VW-1:0] & ((VW'(1) << bits) - VW'(1));
        end
        return '0;
    endfunction

    // offer one item, holding it until accepted
    task automatic offer_value(input logic [VW-1:0] v);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            value_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        value_valid <= 1'b1;
        value_in    <= v;
        do
            @(posedge clk);
        while (!value_ready);
    endtask

    // receiver: random ready gaps, one long hold-off part way through
    initial
    begin : receiver
        int gap;
        int taken;
        taken = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (taken == 150)
            begin
                term_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                gap = no_idle ? 0 : $urandom_range(0, 4);
                if (gap > 0)
                begin
                    term_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            term_ready <= 1'b1;
            do
                @(posedge clk);
            while (!term_valid);
            taken++;
        end
    end

    // reset, stimulus and end of run
    initial
    begin : stimulus
        logic [VW-1:0] directed[$];
        logic [VW-1:0] p39;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: small values, zero, extremes, powers of three and their
        // neighbors, all-plus and all-nonzero expansions, bit patterns
        p39 = three_pow(39);
        directed = '{VW'(1), VW'(2), VW'(3), VW'(4), VW'(5), VW'(0), VW'(8), VW'(13),
                     p39, p39 - VW'(1), p39 + VW'(1),
                     (p39 - VW'(1)) / 2, (p39 + VW'(1)) / 2,
                     {VW{1'b1}}, VW'(1) << (VW - 1),
                     {31{2'b10}}, {31{2'b01}},
                     three_pow(20), three_pow(20) - VW'(1), three_pow(1) + VW'(1),
                     VW'(1000)};
        foreach (directed[i])
            offer_value(directed[i]);

        // random part with one stretch of no idling
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            no_idle = (i >= 100 && i < 180);
            offer_value(random_value());
        end
        no_idle = 1'b0;
        value_valid <= 1'b0;

        // drain
        @(posedge clk);
        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
